// ===== rtl/vt4_pkg.sv =====
// Shared types, constants and binary32 arithmetic steps for the vertex transform unit.
`default_nettype none
package vt4_pkg;

  localparam int unsigned NumRegs   = 8;
  localparam int unsigned RegW      = 64;
  localparam int unsigned CfgAddrW  = 4;
  localparam int unsigned PipeDepth = 15;

  localparam logic [31:0] QNAN_BIT    = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

  localparam logic [RegW-1:0] CFG_RESET [NumRegs] = '{
    64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000
  };

  // multiplier stages
  typedef struct packed {
    logic               spec;
    logic [31:0]        spv;
    logic               sign;
    logic signed [10:0] ex;
    logic [23:0]        ma;
    logic [23:0]        mb;
  } mul1_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spv;
    logic               sign;
    logic signed [10:0] ex;
    logic [47:0]        prod;
  } mul2_t;

  // adder stages
  typedef struct packed {
    logic        spec;
    logic [31:0] spv;
    logic        sub;
    logic        sa;
    logic        sign;
    logic [7:0]  eb;
    logic [23:0] mb;
    logic [23:0] ms;
    logic [7:0]  d;
  } add1_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] spv;
    logic        sub;
    logic        sa;
    logic        sign;
    logic [7:0]  eb;
    logic [23:0] mb;
    logic [60:0] rs;
  } add2_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] spv;
    logic        sign;
    logic [7:0]  eb;
    logic [61:0] r;
  } add3_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] spv;
    logic        sign;
    logic [7:0]  eb;
    logic [61:0] r;
    logic [5:0]  lz;
  } add4_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spv;
    logic               sign;
    logic signed [10:0] ex;
    logic [30:0]        sig;
  } add5_t;

  function automatic logic is_nan(logic [31:0] v);
    return (&v[30:23]) && (|v[22:0]);
  endfunction

  function automatic logic is_inf(logic [31:0] v);
    return (&v[30:23]) && !(|v[22:0]);
  endfunction

  function automatic logic [4:0] lzc24(logic [23:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [30:0] jam31(logic [30:0] v, logic [10:0] n);
    logic [30:0] lost;
    if (n >= 11'd31) return {30'd0, |v};
    lost = v & ~({31{1'b1}} << n[4:0]);
    return (v >> n[4:0]) | {30'd0, |lost};
  endfunction

  // sig has its leading bit at bit 30, value = sig * 2^(ex - 156)
  function automatic logic [31:0] round_pack(logic sign, logic signed [10:0] ex,
                                             logic [30:0] sig);
    logic [30:0] s;
    logic [7:0]  e;
    logic [31:0] sum;
    logic [24:0] q;
    logic        ovf;
    s   = sig;
    e   = ex[7:0];
    ovf = 1'b0;
    sum = {1'b0, sig} + 32'h40;
    if (ex < 0) begin
      s = jam31(sig, 11'(-ex));
      e = 8'd0;
    end else if (ex > 11'sd253 || (ex == 11'sd253 && sum[31])) begin
      ovf = 1'b1;
    end
    sum = {1'b0, s} + 32'h40;
    q   = sum[31:7];
    if (s[6:0] == 7'h40) q[0] = 1'b0;
    if (q == 25'd0) e = 8'd0;
    if (ovf) return {sign, 8'hFF, 23'd0};
    return {sign, 31'd0} + {1'b0, e, 23'd0} + {7'd0, q};
  endfunction

  // a is the matrix element
  function automatic mul1_t mul_s1(logic [31:0] a, logic [31:0] b);
    mul1_t              o;
    logic               za, zb;
    logic [4:0]         lza, lzb;
    logic signed [10:0] ea, eb;
    za     = ~|a[30:0];
    zb     = ~|b[30:0];
    o.sign = a[31] ^ b[31];
    o.spec = 1'b1;
    if (is_nan(a)) o.spv = a | QNAN_BIT;
    else if (is_nan(b)) o.spv = b | QNAN_BIT;
    else if (is_inf(a) || is_inf(b)) o.spv = (za || zb) ? DEFAULT_NAN : {o.sign, 8'hFF, 23'd0};
    else if (za || zb) o.spv = {o.sign, 31'd0};
    else begin
      o.spv  = 32'd0;
      o.spec = 1'b0;
    end
    lza = lzc24({1'b0, a[22:0]});
    lzb = lzc24({1'b0, b[22:0]});
    if (a[30:23] == 8'd0) begin
      o.ma = {1'b0, a[22:0]} << lza;
      ea   = 11'sd1 - $signed({6'd0, lza});
    end else begin
      o.ma = {1'b1, a[22:0]};
      ea   = $signed({3'd0, a[30:23]});
    end
    if (b[30:23] == 8'd0) begin
      o.mb = {1'b0, b[22:0]} << lzb;
      eb   = 11'sd1 - $signed({6'd0, lzb});
    end else begin
      o.mb = {1'b1, b[22:0]};
      eb   = $signed({3'd0, b[30:23]});
    end
    o.ex = ea + eb - 11'sd127;
    return o;
  endfunction

  function automatic mul2_t mul_s2(mul1_t i);
    mul2_t o;
    o.spec = i.spec;
    o.spv  = i.spv;
    o.sign = i.sign;
    o.ex   = i.ex;
    o.prod = 48'(i.ma) * 48'(i.mb);
    return o;
  endfunction

  function automatic logic [31:0] mul_s3(mul2_t i);
    logic [30:0]        sig;
    logic signed [10:0] ex;
    sig = i.prod[47:17] | {30'd0, |i.prod[16:0]};
    ex  = i.ex;
    if (!sig[30]) begin
      ex  = ex - 11'sd1;
      sig = sig << 1;
    end
    return i.spec ? i.spv : round_pack(i.sign, ex, sig);
  endfunction

  // a is the left-hand term
  function automatic add1_t add_s1(logic [31:0] a, logic [31:0] b);
    add1_t       o;
    logic [31:0] big, sml;
    o.spec = 1'b1;
    if (is_nan(a)) o.spv = a | QNAN_BIT;
    else if (is_nan(b)) o.spv = b | QNAN_BIT;
    else if (is_inf(a)) o.spv = (is_inf(b) && a[31] != b[31]) ? DEFAULT_NAN : a;
    else if (is_inf(b)) o.spv = b;
    else begin
      o.spv  = 32'd0;
      o.spec = 1'b0;
    end
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    o.sub  = a[31] ^ b[31];
    o.sa   = a[31];
    o.sign = big[31];
    o.eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    o.mb   = {big[30:23] != 8'd0, big[22:0]};
    o.ms   = {sml[30:23] != 8'd0, sml[22:0]};
    o.d    = o.eb - ((sml[30:23] == 8'd0) ? 8'd1 : sml[30:23]);
    return o;
  endfunction

  function automatic add2_t add_s2(add1_t i);
    add2_t       o;
    logic [60:0] v;
    logic [60:0] lost;
    o.spec = i.spec;
    o.spv  = i.spv;
    o.sub  = i.sub;
    o.sa   = i.sa;
    o.sign = i.sign;
    o.eb   = i.eb;
    o.mb   = i.mb;
    v      = {i.ms, 37'd0};
    lost   = v & ~({61{1'b1}} << i.d[5:0]);
    if (i.d >= 8'd61) o.rs = {60'd0, |i.ms};
    else o.rs = (v >> i.d[5:0]) | {60'd0, |lost};
    return o;
  endfunction

  function automatic add3_t add_s3(add2_t i);
    add3_t       o;
    logic [61:0] rb;
    rb     = {1'b0, i.mb, 37'd0};
    o.r    = i.sub ? rb - {1'b0, i.rs} : rb + {1'b0, i.rs};
    o.sign = i.sign;
    o.eb   = i.eb;
    o.spec = i.spec;
    o.spv  = i.spv;
    // exact zero: -0 only when both addends are -0
    if (!i.spec && o.r == 62'd0) begin
      o.spec = 1'b1;
      o.spv  = i.sub ? 32'd0 : {i.sa, 31'd0};
    end
    return o;
  endfunction

  function automatic add4_t add_s4(add3_t i);
    add4_t o;
    o.spec = i.spec;
    o.spv  = i.spv;
    o.sign = i.sign;
    o.eb   = i.eb;
    o.r    = i.r;
    o.lz   = 6'd0;
    for (int k = 0; k < 62; k++) begin
      if (i.r[k]) o.lz = 6'(61 - k);
    end
    return o;
  endfunction

  function automatic add5_t add_s5(add4_t i);
    add5_t       o;
    logic [61:0] n;
    n      = i.r << i.lz;
    o.spec = i.spec;
    o.spv  = i.spv;
    o.sign = i.sign;
    o.sig  = n[61:31] | {30'd0, |n[30:0]};
    o.ex   = $signed({3'd0, i.eb}) - $signed({5'd0, i.lz});
    return o;
  endfunction

  function automatic logic [31:0] add_s6(add5_t i);
    return i.spec ? i.spv : round_pack(i.sign, i.ex, i.sig);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/vertex_transform_4x4_float_unit.sv =====
// Top level: 4x4 binary32 matrix times vector, one item per cycle.
//
//  channel  | direction | handshake              | payload
//  in_      | slave     | in_tvalid / in_tready  | in_tdata: vec_x, vec_y, vec_z, vec_w
//  out_     | master    | out_tvalid / out_tready| out_tdata: out_x, out_y, out_z, out_w
//  cfg_     | write     | cfg_we                 | cfg_addr, cfg_wdata (64-bit register)
//
// An item passes through 3 multiplier stages and two levels of 6-stage adders on its
// way from acceptance to output. One item enters per cycle while the output moves.
// Reset clears the valid bits and loads the identity matrix.
// When the output stalls the whole pipeline holds; no item is dropped or repeated.
`default_nettype none
module vertex_transform_4x4_float_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [127:0]                  in_tdata,   // vec_x, vec_y, vec_z, vec_w
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [127:0]                  out_tdata,  // out_x, out_y, out_z, out_w
  input  wire logic                          cfg_we,
  input  wire logic [vt4_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [vt4_pkg::RegW-1:0]      cfg_wdata
);

  logic [vt4_pkg::RegW-1:0]      mat_r [vt4_pkg::NumRegs];
  logic [vt4_pkg::PipeDepth-1:0] vld_r;
  logic                          en;

  assign en        = !vld_r[vt4_pkg::PipeDepth-1] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[vt4_pkg::PipeDepth-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vt4_pkg::NumRegs; i++) mat_r[i] <= vt4_pkg::CFG_RESET[i];
    end else if (cfg_we && cfg_addr < vt4_pkg::CfgAddrW'(vt4_pkg::NumRegs)) begin
      mat_r[cfg_addr[2:0]] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[vt4_pkg::PipeDepth-2:0], in_tvalid};
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    vt4_row u_row (
      .clk (clk),
      .en  (en),
      .vec (in_tdata),
      .row ({mat_r[2*r+1], mat_r[2*r]}),
      .res (out_tdata[32*r +: 32])
    );
  end

endmodule
`default_nettype wire

// ===== rtl/vt4_row.sv =====
// One matrix row dotted with the vector: four multipliers and an adder tree, fully pipelined.
`default_nettype none
module vt4_row (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [127:0] vec,   // x, y, z, w from the lowest bit up
  input  wire logic [127:0] row,   // columns 1..4 from the lowest bit up
  output logic      [31:0]  res
);

  vt4_pkg::mul1_t m1_r [4];
  vt4_pkg::mul2_t m2_r [4];
  logic [31:0]    p_r  [4];

  vt4_pkg::add1_t a1_r [3];
  vt4_pkg::add2_t a2_r [3];
  vt4_pkg::add3_t a3_r [3];
  vt4_pkg::add4_t a4_r [3];
  vt4_pkg::add5_t a5_r [3];
  logic [31:0]    s_r  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        m1_r[j] <= vt4_pkg::mul_s1(row[32*j +: 32], vec[32*j +: 32]);
        m2_r[j] <= vt4_pkg::mul_s2(m1_r[j]);
        p_r[j]  <= vt4_pkg::mul_s3(m2_r[j]);
      end
      // first level pairs (p0,p1) and (p2,p3); second level adds the two sums
      a1_r[0] <= vt4_pkg::add_s1(p_r[0], p_r[1]);
      a1_r[1] <= vt4_pkg::add_s1(p_r[2], p_r[3]);
      a1_r[2] <= vt4_pkg::add_s1(s_r[0], s_r[1]);
      for (int k = 0; k < 3; k++) begin
        a2_r[k] <= vt4_pkg::add_s2(a1_r[k]);
        a3_r[k] <= vt4_pkg::add_s3(a2_r[k]);
        a4_r[k] <= vt4_pkg::add_s4(a3_r[k]);
        a5_r[k] <= vt4_pkg::add_s5(a4_r[k]);
        s_r[k]  <= vt4_pkg::add_s6(a5_r[k]);
      end
    end
  end

  assign res = s_r[2];

endmodule
`default_nettype wire

// ===== rtl/vt4_chk.sv =====
// Port-level checker for the vertex transform unit, bound to the top level.
`default_nettype none
module vt4_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("output item dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("stalled item changed");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("input blocked with empty output");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid) else $error("output valid after reset");

endmodule

bind vertex_transform_4x4_float_unit vt4_chk u_vt4_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== tb/vertex_transform_4x4_float_unit_tb.sv =====
// Self-checking testbench for the 4x4 binary32 matrix-vector transform unit.
`default_nettype none
module vertex_transform_4x4_float_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    R0C01 = 4'd0, R0C23 = 4'd1, R1C01 = 4'd2, R1C23 = 4'd3,
    R2C01 = 4'd4, R2C23 = 4'd5, R3C01 = 4'd6, R3C23 = 4'd7,
    RBAD  = 4'd8
  } mat_reg_e;

  localparam logic [31:0] F_ONE  = 32'h3F80_0000;
  localparam logic [31:0] F_PINF = 32'h7F80_0000;
  localparam logic [31:0] F_NINF = 32'hFF80_0000;
  localparam logic [31:0] F_NZ   = 32'h8000_0000;
  localparam logic [31:0] F_MAX  = 32'h7F7F_FFFF;
  localparam logic [31:0] F_SUBN = 32'h0000_0001;
  localparam logic [31:0] F_SNAN = 32'h7F80_0001;
  localparam logic [31:0] F_NEG2 = 32'hC000_0000;
  localparam logic [31:0] F_HALF = 32'h3F00_0000;
  localparam logic [31:0] F_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] F_TINY = 32'h0080_0000;
  localparam logic [31:0] QBIT   = 32'h0040_0000;
  localparam logic [31:0] DNAN   = 32'hFFC0_0000;
  localparam logic [31:0] EXPM   = 32'h7F80_0000;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] w, z, y, x;
  } vec4_t;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready, out_tvalid, out_tready, cfg_we;
  logic [127:0] in_tdata, out_tdata;
  logic [3:0]   cfg_addr;
  logic [63:0]  cfg_wdata;

  logic [63:0]  matrix [8];
  vec4_t        expected_q [$];
  int           errors;
  int unsigned  cycles;
  bit           gaps_on;

  vertex_transform_4x4_float_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------- binary32 arithmetic ----------------
  function automatic bit f_isnan(logic [31:0] v);
    return (v & EXPM) == EXPM && v[22:0] != 0;
  endfunction

  function automatic bit f_isinf(logic [31:0] v);
    return v[30:0] == EXPM[30:0];
  endfunction

  function automatic logic [63:0] jam_right(logic [63:0] v, int n);
    logic [63:0] mask;
    if (n == 0) return v;
    if (n >= 63) return {63'd0, v != 0};
    mask = (64'd1 << n) - 64'd1;
    return (v >> n) | {63'd0, (v & mask) != 0};
  endfunction

  // sig leading bit at 30; value = sig * 2^(ex-156)
  function automatic logic [31:0] f_round(logic sign, int ex, logic [31:0] sig);
    logic [31:0] rb;
    rb = sig & 32'h7F;
    if (ex < 0) begin
      sig = 32'(jam_right({32'd0, sig}, -ex));
      ex = 0;
      rb = sig & 32'h7F;
    end else if (ex > 253 || (ex == 253 && {1'b0, sig} + 33'h40 >= 33'h8000_0000)) begin
      return {sign, 8'hFF, 23'd0};
    end
    sig = (sig + 32'h40) >> 7;
    if (rb == 32'h40) sig[0] = 1'b0;
    if (sig == 0) ex = 0;
    return {sign, 31'd0} + (32'(ex) << 23) + sig;
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    logic        sign, za, zb;
    int          ea, eb, ex;
    logic [31:0] ma, mb, sig;
    logic [63:0] prod;
    sign = a[31] ^ b[31];
    za = a[30:0] == 0;
    zb = b[30:0] == 0;
    if (f_isnan(a)) return a | QBIT;
    if (f_isnan(b)) return b | QBIT;
    if (f_isinf(a) || f_isinf(b)) return (za || zb) ? DNAN : {sign, 8'hFF, 23'd0};
    if (za || zb) return {sign, 31'd0};
    ea = int'(a[30:23]);
    eb = int'(b[30:23]);
    ma = {9'd0, a[22:0]};
    mb = {9'd0, b[22:0]};
    if (ea == 0) begin
      ea = 1;
      while (!ma[23]) begin
        ma = ma << 1;
        ea--;
      end
    end else ma[23] = 1'b1;
    if (eb == 0) begin
      eb = 1;
      while (!mb[23]) begin
        mb = mb << 1;
        eb--;
      end
    end else mb[23] = 1'b1;
    ex = ea + eb - 127;
    prod = {32'd0, ma << 7} * {32'd0, mb << 8};
    sig = 32'(jam_right(prod, 32));
    if (sig < 32'h4000_0000) begin
      ex--;
      sig = sig << 1;
    end
    return f_round(sign, ex, sig);
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    logic [31:0] big, sml, sig;
    logic [63:0] rb, rs, r;
    int          eb, es, p;
    if (f_isnan(a)) return a | QBIT;
    if (f_isnan(b)) return b | QBIT;
    if (f_isinf(a)) return (f_isinf(b) && a[31] != b[31]) ? DNAN : a;
    if (f_isinf(b)) return b;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb = int'(big[30:23]);
    es = int'(sml[30:23]);
    rb = {40'd0, eb != 0, big[22:0]} << 37;
    rs = {40'd0, es != 0, sml[22:0]} << 37;
    if (eb == 0) eb = 1;
    if (es == 0) es = 1;
    rs = jam_right(rs, eb - es);
    r = (a[31] == b[31]) ? rb + rs : rb - rs;
    if (r == 0) return (a[31] == b[31]) ? {a[31], 31'd0} : 32'd0;
    p = 62;
    while (!r[p]) p--;
    if (p > 30) sig = 32'(jam_right(r, p - 30));
    else sig = 32'(r << (30 - p));
    return f_round(big[31], eb - 61 + p, sig);
  endfunction

  function automatic logic [31:0] element(int row, int col);
    logic [63:0] v;
    v = matrix[row * 2 + col / 2];
    return (col % 2) ? v[63:32] : v[31:0];
  endfunction

  function automatic vec4_t transform(vec4_t v);
    logic [31:0] c [4];
    logic [31:0] o [4];
    c = '{v.x, v.y, v.z, v.w};
    for (int r = 0; r < 4; r++)
      o[r] = f_add(f_add(f_mul(element(r, 0), c[0]), f_mul(element(r, 1), c[1])),
                   f_add(f_mul(element(r, 2), c[2]), f_mul(element(r, 3), c[3])));
    return '{w: o[3], z: o[2], y: o[1], x: o[0]};
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v = {v[31], 31'd0};
      3: v = {v[31], 8'hFF, 23'd0};
      4: v[30:23] = 8'(v[30:23] % 8 + 124);
      default: v[30:23] = 8'($urandom_range(100, 154));
    endcase
    return v;
  endfunction

  // leave tvalid high on return; the next item or drain decides what follows
  task automatic send_vertex(vec4_t v);
    cfg_we <= 1'b0;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    expected_q.push_back(transform(v));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(mat_reg_e idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx != RBAD) matrix[idx] = val;
    @(posedge clk);
  endtask

  // ---------------- tests ----------------
  task automatic test_identity_specials();
    logic [31:0] sp [12];
    sp = '{F_ONE, F_PINF, F_NINF, F_NZ, F_MAX, F_SUBN, F_SNAN, F_NEG2,
           F_HALF, F_QNAN, F_TINY, 32'hFFFF_FFFF};
    for (int i = 0; i < 12; i++)
      send_vertex('{w: sp[(i + 3) % 12], z: sp[(i + 2) % 12],
                    y: sp[(i + 1) % 12], x: sp[i]});
    send_vertex('{w: 32'h0, z: 32'h0, y: 32'h0, x: 32'h0});
    send_vertex('{w: F_NZ, z: F_NZ, y: F_NZ, x: F_NZ});
  endtask

  task automatic test_special_matrix();
    drain();
    // infinity times zero, opposite infinities, NaN precedence, overflow
    write_reg(R0C01, {F_PINF, F_PINF});
    write_reg(R0C23, {F_SNAN, F_MAX});
    write_reg(R1C01, {F_NZ, F_NZ});
    write_reg(R1C23, {F_NZ, F_NZ});
    write_reg(R2C01, {F_MAX, F_MAX});
    write_reg(R2C23, {F_MAX, F_MAX});
    write_reg(R3C01, {F_SUBN, F_TINY});
    write_reg(R3C23, {F_HALF, 32'h8000_0001});
    write_reg(RBAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_vertex('{w: F_ONE, z: F_ONE, y: F_NINF, x: F_ONE});
    send_vertex('{w: F_QNAN, z: F_MAX, y: 32'h0, x: F_NZ});
    send_vertex('{w: F_NZ, z: F_NZ, y: F_NZ, x: F_NZ});
    send_vertex('{w: F_TINY, z: F_SUBN, y: F_HALF, x: F_HALF});
    send_vertex('{w: F_NEG2, z: F_MAX, y: F_MAX, x: F_MAX});
    for (int i = 0; i < 6; i++)
      send_vertex('{w: rand_float(), z: rand_float(), y: rand_float(), x: rand_float()});
  endtask

  task automatic test_random_matrices();
    for (int m = 0; m < 12; m++) begin
      drain();
      for (int r = 0; r < 8; r++) begin
        if (m == 0) write_reg(mat_reg_e'(r), 64'd0);
        else if (m == 1) write_reg(mat_reg_e'(r), 64'hFFFF_FFFF_FFFF_FFFF);
        else write_reg(mat_reg_e'(r), {rand_float(), rand_float()});
      end
      if (m == 11) gaps_on = 1'b0;
      for (int i = 0; i < 150; i++)
        send_vertex('{w: rand_float(), z: rand_float(), y: rand_float(), x: rand_float()});
    end
  endtask

  // ---------------- result check ----------------
  always @(posedge clk) begin
    vec4_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.x !== want.x) begin
          $error("out_x expected %h actual %h", want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $error("out_y expected %h actual %h", want.y, got.y);
          errors++;
        end
        if (got.z !== want.z) begin
          $error("out_z expected %h actual %h", want.z, got.z);
          errors++;
        end
        if (got.w !== want.w) begin
          $error("out_w expected %h actual %h", want.w, got.w);
          errors++;
        end
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    int stall;
    if (!rst_n || !gaps_on) out_tready <= 1'b1;
    else if (stall > 0) begin
      stall--;
      if (stall == 0) out_tready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall = $urandom_range(1, 10);
      out_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    gaps_on = 1'b1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    for (int i = 0; i < 8; i++) matrix[i] = vt4_pkg::CFG_RESET[i];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_specials();
    test_special_matrix();
    test_random_matrices();
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
